>>> rtl/core/string_escape_decoder_assert.svh
// Assertion macros shared by the string escape decoder modules.
// The macros expect signals named clk and rst in the module that uses them.
`ifndef STRING_ESCAPE_DECODER_ASSERT_SVH
`define STRING_ESCAPE_DECODER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define SED_ASSERT_HOLD(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("sed: invariant violated");

// An implication checked in the same cycle, outside reset.
`define SED_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sed: implication violated");

`endif

>>> rtl/core/sed_pkg.sv
// Shared types and constants for the string escape decoder.
// No dependencies; used by every module of the block.
package sed_pkg;

  // Largest number of result bytes that one input transaction can cause.
  localparam int MAX_RESULTS = 10;
  // Hex digits held back for replay while an escape is collected.
  localparam int STORE_DEPTH = 7;

  // Characters recognised in the input.
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_A         = 8'h61;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_V         = 8'h76;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_LOWER_U   = 8'h75;
  localparam logic [7:0] CH_UPPER_U   = 8'h55;

  // Bytes produced by the single-letter escapes.
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_BEL = 8'h07;
  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_FF  = 8'h0C;
  localparam logic [7:0] BYTE_VT  = 8'h0B;

  // Hex digits needed by each numeric escape.
  localparam logic [3:0] NEED_X       = 4'd2;
  localparam logic [3:0] NEED_LOWER_U = 4'd4;
  localparam logic [3:0] NEED_UPPER_U = 4'd8;

  // One unit of work from the front end: the result bytes of one input
  // transaction, their number, and whether the literal ends with them.
  typedef struct packed {
    logic [3:0]                        count;
    logic                              string_end;
    logic [MAX_RESULTS-1:0][7:0]       bytes;
  } job_t;

  // Queue occupancy as seen by the producer and the consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> rtl/core/sed_front.sv
// Front end of the string escape decoder: accepts input transactions,
// tracks the escape state and turns each byte into a job. Uses sed_pkg.
`include "string_escape_decoder_assert.svh"

module sed_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          in_byte,
  input  logic                is_last,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                push,
  output sed_pkg::job_t       push_job,
  input  sed_pkg::q_stat_t    stat
);

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_ESC  = 3'b010,
    MODE_HEX  = 3'b100
  } mode_t;

  typedef struct packed {
    logic [2:0]      count;
    logic [3:0][7:0] bytes;
  } utf8_t;

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

  // UTF-8 encoding; the lead byte of an oversized code point keeps only
  // its low eight bits.
  function automatic utf8_t utf8_encode(input logic [31:0] c);
    utf8_t r;
    r = '0;
    if (c < 32'h80) begin
      r.count    = 3'd1;
      r.bytes[0] = c[7:0];
    end else if (c < 32'h800) begin
      r.count    = 3'd2;
      r.bytes[0] = 8'hC0 | c[13:6];
      r.bytes[1] = 8'h80 | {2'b00, c[5:0]};
    end else if (c < 32'h10000) begin
      r.count    = 3'd3;
      r.bytes[0] = 8'hE0 | c[19:12];
      r.bytes[1] = 8'h80 | {2'b00, c[11:6]};
      r.bytes[2] = 8'h80 | {2'b00, c[5:0]};
    end else begin
      r.count    = 3'd4;
      r.bytes[0] = 8'hF0 | c[25:18];
      r.bytes[1] = 8'h80 | {2'b00, c[17:12]};
      r.bytes[2] = 8'h80 | {2'b00, c[11:6]};
      r.bytes[3] = 8'h80 | {2'b00, c[5:0]};
    end
    return r;
  endfunction

  mode_t       mode, mode_next;
  logic [7:0]  letter, letter_next;
  logic [3:0]  needed, needed_next;
  logic [2:0]  seen, seen_next;
  logic [27:0] code_point, code_point_next;
  logic [7:0]  digit_store [sed_pkg::STORE_DEPTH];

  logic        accept;
  logic        store_wr;
  logic [4:0]  hex;
  logic [31:0] cp_full;
  logic [3:0]  seen_ext;
  logic [3:0]  rep_len;
  logic        esc_start;
  logic        hex_done;
  utf8_t       utf8;
  logic [sed_pkg::MAX_RESULTS-1:0][7:0] rep_src;
  logic [sed_pkg::MAX_RESULTS-1:0][7:0] rep_bytes;
  sed_pkg::job_t job;

  assign in_stall  = stat.full;
  assign accept    = in_valid && !stat.full;
  assign hex       = hex_value(in_byte);
  assign cp_full   = {code_point, hex[3:0]};
  assign seen_ext  = {1'b0, seen};
  assign rep_len   = 4'd2 + seen_ext;
  assign esc_start = (in_byte == sed_pkg::CH_BACKSLASH) && !is_last;
  assign hex_done  = (seen_ext + 4'd1) >= needed;
  assign utf8      = utf8_encode(cp_full);

  // Replay sequence: backslash, escape letter, stored digits, then the
  // current byte in the first free place.
  always_comb begin
    rep_src    = '0;
    rep_src[0] = sed_pkg::CH_BACKSLASH;
    rep_src[1] = letter;
    for (int k = 0; k < sed_pkg::STORE_DEPTH; k++) begin
      rep_src[k+2] = digit_store[k];
    end
    for (int i = 0; i < sed_pkg::MAX_RESULTS; i++) begin
      rep_bytes[i] = (4'(i) < rep_len) ? rep_src[i] : in_byte;
    end
  end

  // Classify the byte against the escape state and build its job.
  always_comb begin
    job             = '0;
    mode_next       = mode;
    letter_next     = letter;
    needed_next     = needed;
    seen_next       = seen;
    code_point_next = code_point;
    store_wr        = 1'b0;
    case (mode)
      MODE_HEX: begin
        if (hex[4]) begin
          if (hex_done) begin
            if (letter == sed_pkg::CH_X) begin
              job.count    = 4'd1;
              job.bytes[0] = cp_full[7:0];
            end else begin
              job.count = {1'b0, utf8.count};
              for (int i = 0; i < 4; i++) begin
                job.bytes[i] = utf8.bytes[i];
              end
            end
            mode_next = MODE_IDLE;
          end else if (is_last) begin
            job.bytes = rep_bytes;
            job.count = rep_len + 4'd1;
            mode_next = MODE_IDLE;
          end else begin
            store_wr        = 1'b1;
            seen_next       = seen + 3'd1;
            code_point_next = cp_full[27:0];
          end
        end else begin
          // Bad digit: replay, then treat the byte as if no escape were open.
          job.bytes = rep_bytes;
          job.count = esc_start ? rep_len : rep_len + 4'd1;
          mode_next = esc_start ? MODE_ESC : MODE_IDLE;
        end
      end
      MODE_ESC: begin
        mode_next = MODE_IDLE;
        job.count = 4'd1;
        case (in_byte)
          sed_pkg::CH_N:         job.bytes[0] = sed_pkg::BYTE_LF;
          sed_pkg::CH_T:         job.bytes[0] = sed_pkg::BYTE_TAB;
          sed_pkg::CH_R:         job.bytes[0] = sed_pkg::BYTE_CR;
          sed_pkg::CH_ZERO:      job.bytes[0] = sed_pkg::BYTE_NUL;
          sed_pkg::CH_A:         job.bytes[0] = sed_pkg::BYTE_BEL;
          sed_pkg::CH_B:         job.bytes[0] = sed_pkg::BYTE_BS;
          sed_pkg::CH_F:         job.bytes[0] = sed_pkg::BYTE_FF;
          sed_pkg::CH_V:         job.bytes[0] = sed_pkg::BYTE_VT;
          sed_pkg::CH_BACKSLASH: job.bytes[0] = sed_pkg::CH_BACKSLASH;
          sed_pkg::CH_SQUOTE:    job.bytes[0] = sed_pkg::CH_SQUOTE;
          sed_pkg::CH_DQUOTE:    job.bytes[0] = sed_pkg::CH_DQUOTE;
          sed_pkg::CH_NEWLINE:   job.count    = 4'd0;
          sed_pkg::CH_X, sed_pkg::CH_LOWER_U, sed_pkg::CH_UPPER_U: begin
            if (is_last) begin
              job.count    = 4'd2;
              job.bytes[0] = sed_pkg::CH_BACKSLASH;
              job.bytes[1] = in_byte;
            end else begin
              job.count       = 4'd0;
              mode_next       = MODE_HEX;
              letter_next     = in_byte;
              seen_next       = 3'd0;
              code_point_next = '0;
              needed_next     = (in_byte == sed_pkg::CH_X)       ? sed_pkg::NEED_X :
                                (in_byte == sed_pkg::CH_LOWER_U) ? sed_pkg::NEED_LOWER_U :
                                                                   sed_pkg::NEED_UPPER_U;
            end
          end
          default: begin
            job.count    = 4'd2;
            job.bytes[0] = sed_pkg::CH_BACKSLASH;
            job.bytes[1] = in_byte;
          end
        endcase
      end
      default: begin
        if (esc_start) begin
          mode_next = MODE_ESC;
        end else begin
          job.count    = 4'd1;
          job.bytes[0] = in_byte;
        end
      end
    endcase
    // The final byte closes the literal and leaves no escape open.
    if (is_last) begin
      job.string_end = 1'b1;
      mode_next      = MODE_IDLE;
    end
  end

  assign push     = accept && ((job.count != 4'd0) || is_last);
  assign push_job = job;

  // Escape state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      letter     <= '0;
      needed     <= '0;
      seen       <= '0;
      code_point <= '0;
    end else if (accept) begin
      mode       <= mode_next;
      letter     <= letter_next;
      needed     <= needed_next;
      seen       <= seen_next;
      code_point <= code_point_next;
    end
  end

  // Digit store for replay; only entries of the open escape are ever read.
  always_ff @(posedge clk) begin
    if (accept && store_wr) begin
      digit_store[seen] <= in_byte;
    end
  end

  `SED_ASSERT_IMPLY(a_hex_digits_bounded, mode == MODE_HEX, seen_ext < needed)

endmodule

>>> rtl/core/sed_queue.sv
// Two-entry job queue between the front end and the back end.
// Uses sed_pkg for the job and status types.
`include "string_escape_decoder_assert.svh"

module sed_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sed_pkg::job_t       push_job,
  input  logic                pop,
  output sed_pkg::job_t       head,
  output sed_pkg::q_stat_t    stat
);

  sed_pkg::job_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign head       = entries[rd_ptr];
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  `SED_ASSERT_HOLD(a_no_push_when_full, !(push && stat.full))
  `SED_ASSERT_HOLD(a_no_pop_when_empty, !(pop && stat.empty))

endmodule

>>> rtl/core/sed_back.sv
// Back end of the string escape decoder: walks the head job one byte per
// cycle into the output register when the output is not stalled. Uses sed_pkg for the job types.
`include "string_escape_decoder_assert.svh"

module sed_back (
  input  logic                clk,
  input  logic                rst,
  input  sed_pkg::job_t       head,
  input  sed_pkg::q_stat_t    stat,
  output logic                pop,
  output logic [7:0]          out_byte,
  output logic                has_byte,
  output logic                run_last,
  output logic                string_end,
  output logic                out_valid,
  input  logic                out_stall
);

  logic [3:0] idx;
  logic       advance;
  logic       take;
  logic       at_last;
  logic       job_has_bytes;

  assign advance       = !out_valid || !out_stall;
  assign take          = advance && !stat.empty;
  assign job_has_bytes = (head.count != 4'd0);
  assign at_last       = !job_has_bytes || (idx == head.count - 4'd1);
  assign pop           = take && at_last;

  // Position within the head job.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 4'd0;
    end else if (take) begin
      idx <= at_last ? 4'd0 : idx + 4'd1;
    end
  end

  // Output register; it loads whenever the previous transaction has left.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte   <= job_has_bytes ? head.bytes[idx] : 8'h00;
      has_byte   <= job_has_bytes;
      run_last   <= at_last;
      string_end <= head.string_end && at_last;
    end
  end

  `SED_ASSERT_IMPLY(a_end_closes_run, out_valid && string_end, run_last)
  `SED_ASSERT_IMPLY(a_bare_marker, out_valid && !has_byte, string_end && (out_byte == 8'h00))

endmodule

>>> rtl/core/string_escape_decoder.sv
// Top level of the string escape decoder: front end, job queue, back end.
// Depends on sed_pkg, sed_front, sed_queue and sed_back.
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+--------------------------------------------
//  input   | in_valid / in_stall   | in_byte, is_last
//  output  | out_valid / out_stall | out_byte, has_byte, run_last, string_end
//
// A transaction is taken every cycle while the two-entry job queue has room.
// Each input transaction yields 0 to 10 results; the back end sends one
// result per cycle while the output is not stalled.
// A result is registered first in the job queue, then in the output register.
// Reset is synchronous and empties the queue, the output register and the
// escape state; there is no clearing pass.
// in_stall rises only when the queue is full, i.e. when the output side is
// stalled or busy with multi-byte runs.

module string_escape_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_byte,
  input  logic       is_last,
  input  logic       in_valid,
  output logic       in_stall,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       run_last,
  output logic       string_end,
  output logic       out_valid,
  input  logic       out_stall
);

  logic             push;
  logic             pop;
  sed_pkg::job_t    push_job;
  sed_pkg::job_t    head;
  sed_pkg::q_stat_t stat;

  sed_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_byte  (in_byte),
    .is_last  (is_last),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .push     (push),
    .push_job (push_job),
    .stat     (stat)
  );

  sed_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  sed_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .stat       (stat),
    .pop        (pop),
    .out_byte   (out_byte),
    .has_byte   (has_byte),
    .run_last   (run_last),
    .string_end (string_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );

endmodule
